### sv/ame_pkg.sv
// ----------------------------------------------------------------------------
// ame_pkg: shared types and constants
// Opcodes, status codes and controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package ame_pkg;

  localparam int unsigned PcBits  = 9;
  localparam int unsigned OutBits = 32;

  // opcodes
  localparam logic [3:0] OpAdd    = 4'd1;
  localparam logic [3:0] OpSub    = 4'd2;
  localparam logic [3:0] OpMul    = 4'd3;
  localparam logic [3:0] OpDiv    = 4'd4;
  localparam logic [3:0] OpJmp    = 4'd5;
  localparam logic [3:0] OpJmpn   = 4'd6;
  localparam logic [3:0] OpJmpp   = 4'd7;
  localparam logic [3:0] OpJmpz   = 4'd8;
  localparam logic [3:0] OpCopy   = 4'd9;
  localparam logic [3:0] OpLoad   = 4'd10;
  localparam logic [3:0] OpStore  = 4'd11;
  localparam logic [3:0] OpInput  = 4'd12;
  localparam logic [3:0] OpOutput = 4'd13;
  localparam logic [3:0] OpStop   = 4'd14;

  // status codes
  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StOutput   = 3'd1;
  localparam logic [2:0] StStopped  = 3'd2;
  localparam logic [2:0] StBadPc    = 3'd3;
  localparam logic [2:0] StBadOp    = 3'd4;
  localparam logic [2:0] StBadAddr  = 3'd5;
  localparam logic [2:0] StDivZero  = 3'd6;
  localparam logic [2:0] StHalted   = 3'd7;

  // memory read address select
  typedef enum logic [1:0] {
    RaPc   = 2'd0,
    RaOpA  = 2'd1,
    RaWord = 2'd2
  } raddr_sel_e;

  // datapath commands from the controller
  typedef struct packed {
    logic       load_in;    // capture the input word
    logic       mem_rd;     // issue a memory read
    raddr_sel_e rd_sel;
    logic       pc_inc;
    logic       cap_inst;   // capture read data as opcode word
    logic       cap_a;      // capture read data as operand a
    logic       cap_b;      // capture read data as operand b
    logic       cap_data;   // capture read data as data word
    logic       wr_host;    // host memory write
    logic       wr_acc;     // store acc at operand a
    logic       wr_in;      // store input value at operand a
    logic       wr_copy;    // store data word at operand b
    logic       jump;       // jump to operand a (checked)
    logic       acc_alu;    // acc <- add/sub/load result
    logic       mul_go;
    logic       div_start;
    logic       acc_mul;
    logic       acc_div;
    logic       show_data;  // output_value <- data word
    logic       res_load;   // copy pc, acc and output_value to the result register
  } dp_cmd_t;

  // datapath status to the controller
  typedef struct packed {
    logic       pc_ok;
    logic       a_ok;
    logic       b_ok;
    logic [3:0] op;
    logic       inst_known; // opcode word is a legal small value
    logic       data_zero;
    logic       acc_neg;
    logic       acc_zero;
    logic       div_done;
  } dp_stat_t;

endpackage

### sv/ame_if.sv
// ----------------------------------------------------------------------------
// ame_if: valid/ready channel
// Carries one word of type T between a source and a sink.
// ----------------------------------------------------------------------------
interface ame_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/ame_div.sv
// ----------------------------------------------------------------------------
// ame_div: iterative signed divider
// Restoring division, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module ame_div #(
  parameter int unsigned WordBits = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [WordBits-1:0] num_i,
  input  logic [WordBits-1:0] den_i,
  output logic                done_o,
  output logic [WordBits-1:0] quot_o
);
  localparam int unsigned CntBits = $clog2(WordBits + 1);

  logic [WordBits-1:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic                neg_q, neg_d, busy_q, busy_d;
  logic [CntBits-1:0]  cnt_q, cnt_d;
  logic [WordBits:0]   trial;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    neg_d  = neg_q;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    trial  = '0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i[WordBits-1] ? (~num_i + 1'b1) : num_i;
      den_d  = den_i[WordBits-1] ? (~den_i + 1'b1) : den_i;
      neg_d  = num_i[WordBits-1] ^ den_i[WordBits-1];
      busy_d = 1'b1;
      cnt_d  = CntBits'(WordBits);
    end else if (busy_q) begin
      trial = {rem_q, quo_q[WordBits-1]} - {1'b0, den_q};
      if (!trial[WordBits]) begin
        rem_d = trial[WordBits-1:0];
        quo_d = {quo_q[WordBits-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[WordBits-2:0], quo_q[WordBits-1]};
        quo_d = {quo_q[WordBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign done_o = !busy_q && !start_i;
  assign quot_o = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

### sv/ame_datapath.sv
// ----------------------------------------------------------------------------
// ame_datapath: memory, PC, accumulator and arithmetic
// Executes commands from the controller and reports compare results.
// ----------------------------------------------------------------------------
module ame_datapath #(
  parameter int unsigned MemWords = 256,
  parameter int unsigned WordBits = 32,
  parameter int unsigned AddrBits = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ame_pkg::dp_cmd_t            cmd_i,
  output ame_pkg::dp_stat_t           stat_o,
  input  logic [ame_pkg::PcBits-1:0]  prog_len_i,
  input  logic [AddrBits-1:0]         address_i,
  input  logic [31:0]                 write_data_i,
  input  logic [31:0]                 input_value_i,
  output logic [ame_pkg::PcBits-1:0]  pc_o,
  output logic [31:0]                 acc_o,
  output logic [31:0]                 out_val_o
);
  import ame_pkg::*;

  localparam int unsigned LenBits = $clog2(MemWords + 1);
  localparam int unsigned PBits   = (LenBits > PcBits) ? LenBits : PcBits;

  logic [WordBits-1:0] mem [MemWords];
  logic [WordBits-1:0] rdata_q;
  logic [WordBits-1:0] inst_q, a_q, b_q, data_q, acc_q, prod_q, hwd_q, inv_q;
  logic [AddrBits-1:0] haddr_q;
  logic [LenBits-1:0]  pc_q, eff_len;
  logic [31:0]         outv_q;
  logic [PcBits-1:0]   res_pc_q;
  logic [31:0]         res_acc_q, res_outv_q;
  logic [AddrBits-1:0] raddr, waddr;
  logic [WordBits-1:0] wdata;
  logic                wen;
  logic [WordBits-1:0] quot;

  // program length clamps at the memory size
  assign eff_len = ({{(PBits-PcBits){1'b0}}, prog_len_i} > PBits'(MemWords))
                 ? LenBits'(MemWords) : LenBits'(prog_len_i);

  function automatic logic addr_ok(input logic [WordBits-1:0] w,
                                   input logic [LenBits-1:0] len);
    logic ok;
    if (WordBits > LenBits) begin
      ok = !w[WordBits-1] && (w < {{(WordBits-LenBits){1'b0}}, len});
    end else begin
      ok = !w[WordBits-1] && (LenBits'(w) < len);
    end
    return ok;
  endfunction

  always_comb begin
    case (cmd_i.rd_sel)
      RaPc:    raddr = AddrBits'(pc_q);
      RaOpA:   raddr = a_q[AddrBits-1:0];
      default: raddr = a_q[AddrBits-1:0];
    endcase
    wen   = cmd_i.wr_host | cmd_i.wr_acc | cmd_i.wr_in | cmd_i.wr_copy;
    waddr = cmd_i.wr_host ? haddr_q
          : (cmd_i.wr_copy ? b_q[AddrBits-1:0] : a_q[AddrBits-1:0]);
    wdata = cmd_i.wr_host ? hwd_q
          : (cmd_i.wr_acc ? acc_q : (cmd_i.wr_in ? inv_q : data_q));
  end

  always_ff @(posedge clk_i) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (cmd_i.mem_rd) begin
      rdata_q <= mem[raddr];
    end
  end

  ame_div #(.WordBits(WordBits)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (acc_q),
    .den_i  (data_q),
    .done_o (stat_o.div_done),
    .quot_o (quot)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      haddr_q <= address_i;
      hwd_q   <= WordBits'($signed(write_data_i));
      inv_q   <= WordBits'($signed(input_value_i));
    end
    if (cmd_i.cap_inst) inst_q <= rdata_q;
    if (cmd_i.cap_a)    a_q    <= rdata_q;
    if (cmd_i.cap_b)    b_q    <= rdata_q;
    if (cmd_i.cap_data) data_q <= rdata_q;
    if (cmd_i.mul_go)   prod_q <= acc_q * data_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q       <= '0;
      acc_q      <= '0;
      outv_q     <= '0;
      res_pc_q   <= '0;
      res_acc_q  <= '0;
      res_outv_q <= '0;
    end else begin
      if (cmd_i.pc_inc) begin
        pc_q <= pc_q + 1'b1;
      end else if (cmd_i.jump) begin
        pc_q <= addr_ok(a_q, eff_len) ? LenBits'(a_q) : eff_len;
      end
      if (cmd_i.acc_alu) begin
        case (inst_q[3:0])
          OpAdd:   acc_q <= acc_q + data_q;
          OpSub:   acc_q <= acc_q - data_q;
          default: acc_q <= data_q;
        endcase
      end else if (cmd_i.acc_mul) begin
        acc_q <= prod_q;
      end else if (cmd_i.acc_div) begin
        acc_q <= quot;
      end
      if (cmd_i.load_in) begin
        outv_q <= '0;
      end else if (cmd_i.show_data) begin
        outv_q <= 32'($signed(data_q));
      end
      if (cmd_i.res_load) begin
        res_pc_q   <= PcBits'(pc_q);
        res_acc_q  <= 32'($signed(acc_q));
        res_outv_q <= outv_q;
      end
    end
  end

  assign stat_o.pc_ok      = pc_q < eff_len;
  assign stat_o.a_ok       = addr_ok(a_q, eff_len);
  assign stat_o.b_ok       = addr_ok(b_q, eff_len);
  assign stat_o.op         = inst_q[3:0];
  assign stat_o.inst_known = (inst_q >= WordBits'(OpAdd)) && (inst_q <= WordBits'(OpStop));
  assign stat_o.data_zero  = data_q == '0;
  assign stat_o.acc_neg    = acc_q[WordBits-1];
  assign stat_o.acc_zero   = acc_q == '0;

  assign pc_o      = res_pc_q;
  assign acc_o     = res_acc_q;
  assign out_val_o = res_outv_q;

endmodule

### sv/ame_ctrl.sv
// ----------------------------------------------------------------------------
// ame_ctrl: instruction sequencer
// Steps fetch, operand reads, execute and result handoff for each execute word.
// ----------------------------------------------------------------------------
module ame_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_op_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [2:0]           status_o,
  output logic                 used_input_o,
  output ame_pkg::dp_cmd_t     cmd_o,
  input  ame_pkg::dp_stat_t    stat_i
);
  import ame_pkg::*;

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SFetch = 4'd1;
  localparam logic [3:0] SInst  = 4'd2;
  localparam logic [3:0] SOpA   = 4'd3;
  localparam logic [3:0] SOpB   = 4'd4;
  localparam logic [3:0] SDecode= 4'd5;
  localparam logic [3:0] SData  = 4'd6;
  localparam logic [3:0] SExec  = 4'd7;
  localparam logic [3:0] SMul   = 4'd8;
  localparam logic [3:0] SDiv   = 4'd9;
  localparam logic [3:0] SDone  = 4'd10;
  localparam logic [3:0] SHost  = 4'd11;
  localparam logic [3:0] SRdA   = 4'd12;
  localparam logic [3:0] SRdB   = 4'd13;
  localparam logic [3:0] SDivW  = 4'd14;

  logic [3:0] state_q, state_d;
  logic [2:0] st_q, st_d;
  logic       used_q, used_d, halt_q, halt_d, ovalid_q, ovalid_d, copy_q, copy_d;
  logic [2:0] res_st_q;
  logic       res_used_q;

  function automatic logic needs_addr(input logic [3:0] op);
    return op == OpAdd || op == OpSub || op == OpMul || op == OpDiv ||
           op == OpLoad || op == OpStore || op == OpInput || op == OpOutput;
  endfunction

  always_comb begin
    cmd_o    = '0;
    state_d  = state_q;
    st_d     = st_q;
    used_d   = used_q;
    halt_d   = halt_q;
    ovalid_d = ovalid_q;
    copy_d   = copy_q;
    if (ovalid_q && out_ready_i) begin
      ovalid_d = 1'b0;
    end
    case (state_q)
      SIdle: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.load_in = 1'b1;
          st_d   = StOk;
          used_d = 1'b0;
          if (!in_op_i) begin
            state_d = SHost;
          end else if (halt_q) begin
            st_d    = StHalted;
            state_d = SDone;
          end else begin
            state_d = SFetch;
          end
        end
      end
      SHost: begin
        cmd_o.wr_host = 1'b1;
        state_d = SDone;
      end
      SFetch: begin
        // fetch the opcode word
        if (!stat_i.pc_ok) begin
          st_d = StBadPc; state_d = SDone;
        end else begin
          cmd_o.mem_rd = 1'b1; cmd_o.rd_sel = RaPc; cmd_o.pc_inc = 1'b1;
          state_d = SInst;
        end
      end
      SInst: begin
        cmd_o.cap_inst = 1'b1;
        state_d = SOpA;
      end
      SOpA: begin
        if (stat_i.inst_known && stat_i.op == OpStop) begin
          st_d = StStopped; state_d = SDone;
        end else if (!stat_i.pc_ok) begin
          st_d = StBadPc; state_d = SDone;
        end else begin
          cmd_o.mem_rd = 1'b1; cmd_o.rd_sel = RaPc; cmd_o.pc_inc = 1'b1;
          state_d = SRdA;
        end
      end
      SRdA: begin
        cmd_o.cap_a = 1'b1;
        copy_d = stat_i.inst_known && stat_i.op == OpCopy;
        state_d = (stat_i.inst_known && stat_i.op == OpCopy) ? SOpB : SDecode;
      end
      SOpB: begin
        if (!stat_i.pc_ok) begin
          st_d = StBadPc; state_d = SDone;
        end else begin
          cmd_o.mem_rd = 1'b1; cmd_o.rd_sel = RaPc; cmd_o.pc_inc = 1'b1;
          state_d = SRdB;
        end
      end
      SRdB: begin
        cmd_o.cap_b = 1'b1;
        state_d = SDecode;
      end
      SDecode: begin
        state_d = SDone;
        if (!stat_i.inst_known) begin
          st_d = StBadOp;
        end else if (copy_q) begin
          if (!stat_i.a_ok || !stat_i.b_ok) begin
            st_d = StBadAddr;
          end else begin
            cmd_o.mem_rd = 1'b1; cmd_o.rd_sel = RaOpA; state_d = SData;
          end
        end else begin
          case (stat_i.op)
            OpJmp:  cmd_o.jump = 1'b1;
            OpJmpn: cmd_o.jump = stat_i.acc_neg;
            OpJmpp: cmd_o.jump = !stat_i.acc_neg && !stat_i.acc_zero;
            OpJmpz: cmd_o.jump = stat_i.acc_zero;
            default: begin
              if (!needs_addr(stat_i.op)) begin
                st_d = StBadOp;
              end else if (!stat_i.a_ok) begin
                st_d = StBadAddr;
              end else if (stat_i.op == OpStore) begin
                cmd_o.wr_acc = 1'b1;
              end else if (stat_i.op == OpInput) begin
                cmd_o.wr_in = 1'b1; used_d = 1'b1;
              end else begin
                cmd_o.mem_rd = 1'b1; cmd_o.rd_sel = RaWord; state_d = SData;
              end
            end
          endcase
        end
      end
      SData: begin
        cmd_o.cap_data = 1'b1;
        state_d = SExec;
      end
      SExec: begin
        state_d = SDone;
        if (copy_q) begin
          cmd_o.wr_copy = 1'b1;
        end else begin
          case (stat_i.op)
            OpMul:    begin cmd_o.mul_go = 1'b1; state_d = SMul; end
            OpDiv: begin
              if (stat_i.data_zero) begin
                st_d = StDivZero;
              end else begin
                cmd_o.div_start = 1'b1; state_d = SDivW;
              end
            end
            OpOutput: begin cmd_o.show_data = 1'b1; st_d = StOutput; end
            default:  cmd_o.acc_alu = 1'b1;
          endcase
        end
      end
      SMul: begin
        cmd_o.acc_mul = 1'b1;
        state_d = SDone;
      end
      SDivW: begin
        state_d = SDiv;
      end
      SDiv: begin
        if (stat_i.div_done) begin
          cmd_o.acc_div = 1'b1;
          state_d = SDone;
        end
      end
      SDone: begin
        // hand the result to the output register once it is free
        if (!ovalid_d) begin
          ovalid_d = 1'b1;
          cmd_o.res_load = 1'b1;
          if (st_q >= StStopped && st_q != StHalted) begin
            halt_d = 1'b1;
          end
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SIdle;
      st_q       <= StOk;
      used_q     <= 1'b0;
      halt_q     <= 1'b0;
      ovalid_q   <= 1'b0;
      copy_q     <= 1'b0;
      res_st_q   <= StOk;
      res_used_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      st_q     <= st_d;
      used_q   <= used_d;
      halt_q   <= halt_d;
      ovalid_q <= ovalid_d;
      copy_q   <= copy_d;
      if (cmd_o.res_load) begin
        res_st_q   <= st_q;
        res_used_q <= used_q;
      end
    end
  end

  // the output holds while the next word is taken but not done
  assign in_ready_o   = state_q == SIdle;
  assign out_valid_o  = ovalid_q;
  assign status_o     = res_st_q;
  assign used_input_o = res_used_q;

`ifndef SYNTH
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd_o.wr_host, cmd_o.wr_acc, cmd_o.wr_in, cmd_o.wr_copy}) <= 1)
    else $error("more than one memory write");
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q)
    else $error("halt cleared");
  a_used_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wr_in |=> used_q)
    else $error("input store not flagged");
`endif

endmodule

### sv/accumulator_machine_executor.sv
// ----------------------------------------------------------------------------
// accumulator_machine_executor: 14-opcode accumulator machine
// Sequencer plus datapath; one result word for every input word.
// ----------------------------------------------------------------------------
// A write word stores write_data at address, then hands off its result. An
// execute word runs one instruction from a single-port memory, each read
// being a read step followed by a capture step: jumps, STORE and INPUT read
// two words, ADD, SUB, LOAD, OUTPUT, MUL and DIV three and COPY four; DIV
// then waits on the bit-serial divider (one quotient bit per cycle). A halted
// execute goes straight to handoff, faults end early. One word is in work at
// a time; the finished result moves to an output register, so the next word
// is accepted while it waits, and that word stalls at handoff until the
// result is taken. Any fault or STOP halts execution until reset; writes
// still work while halted. The memory has no reset; read only locations
// written.
module accumulator_machine_executor #(
  parameter int unsigned MemWords = 256,
  parameter int unsigned WordBits = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [ame_pkg::PcBits-1:0] cfg_wdata_i,
  ame_if.sink                        in_if,
  ame_if.source                      out_if
);
  import ame_pkg::*;

  localparam int unsigned AddrBits = $clog2(MemWords);

  logic [PcBits-1:0] prog_len_q;
  dp_cmd_t           cmd;
  dp_stat_t          stat;
  logic [2:0]        status;
  logic              used;
  logic [PcBits-1:0] pc;
  logic [31:0]       acc, outv;

  // program length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_len_q <= '0;
    end else if (cfg_we_i) begin
      prog_len_q <= cfg_wdata_i;
    end
  end

  ame_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_op_i     (in_if.data.operation),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .status_o    (status),
    .used_input_o(used),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  ame_datapath #(
    .MemWords(MemWords), .WordBits(WordBits), .AddrBits(AddrBits)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .prog_len_i   (prog_len_q),
    .address_i    (AddrBits'(in_if.data.address)),
    .write_data_i (in_if.data.write_data),
    .input_value_i(in_if.data.input_value),
    .pc_o         (pc),
    .acc_o        (acc),
    .out_val_o    (outv)
  );

  // result fields come from the output register and hold while valid is up
  assign out_if.data.pc           = pc;
  assign out_if.data.acc          = acc;
  assign out_if.data.status       = status;
  assign out_if.data.output_value = outv;
  assign out_if.data.used_input   = used;

endmodule
